// ===== src/hbl_pkg.sv =====
`default_nettype none

package hbl_pkg;

   localparam int ID_W    = 31;
   localparam int MISS_W  = 4;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   localparam logic [MISS_W-1:0] MISS_MAX           = 4'd15;
   localparam logic [MISS_W-1:0] DEFAULT_MISS_LIMIT = 4'd3;

   // command codes (req_tuser)
   localparam logic [CMD_W-1:0] CMD_REGISTER  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK      = 2'd2;

   // status codes (rsp_tuser[1:0])
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   // one table entry as held by a cell
   typedef struct packed {
      logic              valid;
      logic              alive;
      logic [MISS_W-1:0] misses;
      logic [ID_W-1:0]   id;
   } entry_type;

   // ring control from the sequencer to the chain
   typedef struct packed {
      logic      shift;
      entry_type tail;
   } ring_ctl_type;

endpackage

`default_nettype wire

// ===== src/hbl_cell.sv =====
`default_nettype none

module hbl_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     shift,
   input  wire hbl_pkg::entry_type d,
   output hbl_pkg::entry_type      q
);
   import hbl_pkg::*;

   entry_type entry_ff;

   // flags and counter are cleared by reset, the id is plain payload
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid  <= 1'b0;
         entry_ff.alive  <= 1'b0;
         entry_ff.misses <= '0;
      end else if (shift) begin
         entry_ff.valid  <= d.valid;
         entry_ff.alive  <= d.alive;
         entry_ff.misses <= d.misses;
      end
      if (shift) begin
         entry_ff.id <= d.id;
      end
   end

   assign q = entry_ff;

endmodule

`default_nettype wire

// ===== src/hbl_ctrl.sv =====
`default_nettype none

module hbl_ctrl #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire                     clock,
   input  wire                     reset,
   // command words
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [1:0]              req_tuser,
   input  wire  [31:0]             req_tdata,
   // result words
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [2:0]              rsp_tuser,
   output logic [31:0]             rsp_tdata,
   output logic                    rsp_tlast,
   // miss limit register
   input  wire                     csr_wr_en,
   input  wire  [3:0]              csr_wr_data,
   // ring of cells
   input  wire hbl_pkg::entry_type head,
   output hbl_pkg::ring_ctl_type   ring
);
   import hbl_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_HB,
      ST_TICK,
      ST_FINAL
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              free_found_ff, free_found_in;
   logic              dup_ff, dup_in;
   logic              hit_ff, hit_in;
   logic              pend_ff, pend_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;
   logic [ID_W-1:0]   cmd_id_ff, cmd_id_in;
   logic [STAT_W-1:0] fin_status_ff, fin_status_in;
   logic [MISS_W-1:0] miss_limit_ff, miss_limit_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic              rsp_rv_ff, rsp_rv_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              pass_end;
   logic              id_match;
   logic [MISS_W-1:0] miss_next;
   logic              remove;
   logic              load;
   logic [STAT_W-1:0] ld_status;
   logic              ld_rv;
   logic [ID_W-1:0]   ld_id;
   logic              ld_last;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pass_end  = (idx_ff == LAST_IDX);
   assign id_match  = head.valid && (head.id == cmd_id_ff);
   assign miss_next = (head.misses != MISS_MAX) ? head.misses + 4'd1 : MISS_MAX;
   assign remove    = head.valid && !head.alive && (miss_next >= miss_limit_ff);

   // sequencer: one pass rotates the whole ring past the head cell
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      free_idx_in   = free_idx_ff;
      free_found_in = free_found_ff;
      dup_in        = dup_ff;
      hit_in        = hit_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      cmd_id_in     = cmd_id_ff;
      fin_status_in = fin_status_ff;
      miss_limit_in = csr_wr_en ? csr_wr_data : miss_limit_ff;
      ring.shift    = 1'b0;
      ring.tail     = head;
      load          = 1'b0;
      ld_status     = STAT_OK;
      ld_rv         = 1'b0;
      ld_id         = '0;
      ld_last       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_id_in     = req_tdata[ID_W-1:0];
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               hit_in        = 1'b0;
               pend_in       = 1'b0;
               case (req_tuser)
                  CMD_REGISTER:  state_in = ST_SCAN;
                  CMD_HEARTBEAT: state_in = ST_HB;
                  CMD_TICK:      state_in = ST_TICK;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end

         // register, first pass: duplicate check and lowest free slot
         ST_SCAN: begin
            ring.shift = 1'b1;
            if (id_match) begin
               dup_in = 1'b1;
            end
            if (!head.valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (pass_end) begin
               if (dup_in) begin
                  fin_status_in = STAT_DUPLICATE;
                  state_in      = ST_FINAL;
               end else if (!free_found_in) begin
                  fin_status_in = STAT_FULL;
                  state_in      = ST_FINAL;
               end else begin
                  state_in = ST_INSERT;
               end
            end
         end

         // register, second pass: write the new entry into the free slot
         ST_INSERT: begin
            ring.shift = 1'b1;
            if (idx_ff == free_idx_ff) begin
               ring.tail.valid  = 1'b1;
               ring.tail.alive  = 1'b1;
               ring.tail.misses = '0;
               ring.tail.id     = cmd_id_ff;
            end
            if (pass_end) begin
               fin_status_in = STAT_OK;
               state_in      = ST_FINAL;
            end
         end

         ST_HB: begin
            ring.shift = 1'b1;
            if (id_match) begin
               ring.tail.alive = 1'b1;
               hit_in          = 1'b1;
            end
            if (pass_end) begin
               fin_status_in = hit_in ? STAT_OK : STAT_NOT_FOUND;
               state_in      = ST_FINAL;
            end
         end

         // tick sweep; a removal is held back one step so the last one gets tlast
         ST_TICK: begin
            if (remove) begin
               if (!pend_ff || out_free) begin
                  ring.shift       = 1'b1;
                  ring.tail.valid  = 1'b0;
                  ring.tail.alive  = 1'b0;
                  ring.tail.misses = '0;
                  if (pend_ff) begin
                     load  = 1'b1;
                     ld_rv = 1'b1;
                     ld_id = pend_id_ff;
                  end
                  pend_in    = 1'b1;
                  pend_id_in = head.id;
               end
            end else begin
               ring.shift = 1'b1;
               if (head.valid && head.alive) begin
                  ring.tail.alive  = 1'b0;
                  ring.tail.misses = '0;
               end else if (head.valid) begin
                  ring.tail.misses = miss_next;
               end
            end
            if (ring.shift && pass_end) begin
               fin_status_in = STAT_OK;
               state_in      = ST_FINAL;
            end
         end

         ST_FINAL: begin
            if (out_free) begin
               load      = 1'b1;
               ld_status = fin_status_ff;
               ld_rv     = pend_ff;
               ld_id     = pend_ff ? pend_id_ff : '0;
               ld_last   = 1'b1;
               pend_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      if (ring.shift) begin
         idx_in = pass_end ? '0 : idx_ff + IDX_W'(1);
      end

      // output register
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_rv_in     = rsp_rv_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ld_status;
         rsp_rv_in     = ld_rv;
         rsp_id_in     = ld_id;
         rsp_last_in   = ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         dup_ff        <= 1'b0;
         hit_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         miss_limit_ff <= DEFAULT_MISS_LIMIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         free_found_ff <= free_found_in;
         dup_ff        <= dup_in;
         hit_ff        <= hit_in;
         pend_ff       <= pend_in;
         miss_limit_ff <= miss_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      free_idx_ff   <= free_idx_in;
      pend_id_ff    <= pend_id_in;
      cmd_id_ff     <= cmd_id_in;
      fin_status_ff <= fin_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rv_ff     <= rsp_rv_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_rv_ff, rsp_status_ff};
   assign rsp_tdata  = {1'b0, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ring is back in slot order whenever no pass is running
   a_idle_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (idx_ff == '0))
      else $error("ring not realigned at idle");

   // insert only after a clean scan that found a free slot
   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (!dup_ff && free_found_ff))
      else $error("insert pass without free slot or with duplicate");

   // a held removal only exists within a tick
   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_TICK || state_ff == ST_FINAL))
      else $error("pending removal outside tick");

   // a removal result always reports status ok
   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rv_ff) |-> (rsp_status_ff == STAT_OK))
      else $error("removal reported with error status");

   // a real command keeps the input closed for at least the next cycle
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == CMD_REGISTER || req_tuser == CMD_HEARTBEAT
       || req_tuser == CMD_TICK)) |=> !req_tready)
      else $error("input reopened right after a command");

endmodule

`default_nettype wire

// ===== src/heartbeat_liveness_table_unit.sv =====
// Heartbeat liveness table: tracks up to TABLE_ENTRIES client ids.
// Command words arrive on req_*: tuser selects register, heartbeat or tick,
// tdata carries the client id. cmd 3 is taken and dropped with no result.
// Result words leave on rsp_*: tuser holds status and a removed flag,
// tdata the removed id, tlast marks the final word of a command.
// The entries sit in a ring of cells; a heartbeat or tick rotates the ring
// once past a head cell where all compares and updates happen, a register
// once, or twice (duplicate scan, then insert if the id is new and a slot
// is free); one slot a cycle while no tick halts on a held removal.
// The final word is loaded once the last pass ends and the output register
// is free; req_tready rises in the cycle after that word is loaded.
// A tick gives one word per removed entry in slot order, or one empty word.
// Only one command is in flight; req_tready is high while the unit is idle.
// A single output register holds the pending word; when the receiver stalls
// the tick sweep halts at the next removal until that word is taken. Reset
// empties the table and sets the miss limit to 3; the user writes the miss
// limit through csr_wr_en / csr_wr_data while idle, unchecked by the block.
`default_nettype none

module heartbeat_liveness_table_unit #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [1:0]  req_tuser,   // [1:0] cmd
   input  wire  [31:0] req_tdata,   // [30:0] client_id, [31] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] removed_valid
   output logic [31:0] rsp_tdata,   // [30:0] removed_id, [31] zero
   output logic        rsp_tlast,   // last
   input  wire         csr_wr_en,
   input  wire  [3:0]  csr_wr_data  // [3:0] miss_limit
);
   import hbl_pkg::*;

   entry_type    cell_q [TABLE_ENTRIES];
   ring_ctl_type ring;

   // chain of cells, slot 0 at the head, data moves toward lower slots
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      if (i == TABLE_ENTRIES - 1) begin : g_tail
         hbl_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring.shift),
            .d     (ring.tail),
            .q     (cell_q[i])
         );
      end else begin : g_mid
         hbl_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring.shift),
            .d     (cell_q[i+1]),
            .q     (cell_q[i])
         );
      end
   end

   hbl_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (cell_q[0]),
      .ring        (ring)
   );

endmodule

`default_nettype wire

// ===== dv/heartbeat_liveness_table_unit_tb.sv =====
package hbl_tb_pkg;

   import hbl_pkg::*;

   // one result word as seen on rsp_*
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              removed;
      logic [ID_W-1:0]   removed_id;
      logic              last;
   } liveness_word_type;

   // Mirrors the liveness table and queues the words each command should produce.
   class liveness_scoreboard #(int DEPTH = 64);
      bit                tbl_valid  [DEPTH];
      bit [ID_W-1:0]     tbl_id     [DEPTH];
      bit                tbl_alive  [DEPTH];
      bit [MISS_W-1:0]   tbl_misses [DEPTH];
      bit [MISS_W-1:0]   miss_limit = DEFAULT_MISS_LIMIT;
      liveness_word_type expected_q [$];
      int                errors;

      function int pending();
         return expected_q.size();
      endfunction

      function int find_slot(logic [ID_W-1:0] id);
         for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i] && tbl_id[i] == id) return i;
         end
         return -1;
      endfunction

      function void push_word(logic [STAT_W-1:0] status, logic removed,
                              logic [ID_W-1:0] id, logic last);
         liveness_word_type w;
         w.status     = status;
         w.removed    = removed;
         w.removed_id = id;
         w.last       = last;
         expected_q.push_back(w);
      endfunction

      // called once per accepted command word
      function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
         int slot;
         int removed_cnt;
         case (cmd)
            CMD_REGISTER: begin
               if (find_slot(id) >= 0) begin
                  push_word(STAT_DUPLICATE, 1'b0, '0, 1'b1);
               end else begin
                  slot = -1;
                  for (int i = 0; i < DEPTH; i++) begin
                     if (!tbl_valid[i] && slot < 0) slot = i;
                  end
                  if (slot < 0) begin
                     push_word(STAT_FULL, 1'b0, '0, 1'b1);
                  end else begin
                     tbl_valid[slot]  = 1'b1;
                     tbl_id[slot]     = id;
                     tbl_alive[slot]  = 1'b1;
                     tbl_misses[slot] = '0;
                     push_word(STAT_OK, 1'b0, '0, 1'b1);
                  end
               end
            end
            CMD_HEARTBEAT: begin
               slot = find_slot(id);
               if (slot < 0) begin
                  push_word(STAT_NOT_FOUND, 1'b0, '0, 1'b1);
               end else begin
                  tbl_alive[slot] = 1'b1;
                  push_word(STAT_OK, 1'b0, '0, 1'b1);
               end
            end
            CMD_TICK: begin
               // sweep in slot order; alive entries get another chance
               removed_cnt = 0;
               for (int i = 0; i < DEPTH; i++) begin
                  if (tbl_valid[i]) begin
                     if (tbl_alive[i]) begin
                        tbl_alive[i]  = 1'b0;
                        tbl_misses[i] = '0;
                     end else begin
                        if (tbl_misses[i] < MISS_MAX) tbl_misses[i]++;
                        if (tbl_misses[i] >= miss_limit) begin
                           tbl_valid[i]  = 1'b0;
                           tbl_misses[i] = '0;
                           push_word(STAT_OK, 1'b1, tbl_id[i], 1'b0);
                           removed_cnt++;
                        end
                     end
                  end
               end
               if (removed_cnt == 0) push_word(STAT_OK, 1'b0, '0, 1'b1);
               else expected_q[expected_q.size()-1].last = 1'b1;
            end
            default: ;  // unused code is dropped without a word
         endcase
      endfunction

      function void compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            errors++;
         end
      endfunction

      // called once per accepted result word
      function void check_response(liveness_word_type got);
         liveness_word_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected word status %0d removed %0b id 0x%0h last %0b",
                     $time, got.status, got.removed, got.removed_id, got.last);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", ID_W'(want.status), ID_W'(got.status));
         compare_field("removed_valid", ID_W'(want.removed), ID_W'(got.removed));
         compare_field("removed_id", want.removed_id, got.removed_id);
         compare_field("last", ID_W'(want.last), ID_W'(got.last));
      endfunction
   endclass

endpackage

module heartbeat_liveness_table_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import hbl_pkg::*;
   import hbl_tb_pkg::*;

   localparam int ENTRIES      = 64;
   localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int POOL_SIZE    = 24;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [CMD_W-1:0]  req_tuser   = '0;
   logic [31:0]       req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [2:0]        rsp_tuser;
   logic [31:0]       rsp_tdata;
   logic              rsp_tlast;
   logic              csr_wr_en   = 1'b0;
   logic [MISS_W-1:0] csr_wr_data = '0;

   liveness_scoreboard #(ENTRIES) sb;
   logic [ID_W-1:0] id_pool [POOL_SIZE];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request  = 0;

   heartbeat_liveness_table_unit #(.TABLE_ENTRIES(ENTRIES)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // result side: random stalls, plus a long hold-off when requested
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      liveness_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status     = rsp_tuser[1:0];
         got.removed    = rsp_tuser[2];
         got.removed_id = rsp_tdata[ID_W-1:0];
         got.last       = rsp_tlast;
         sb.check_response(got);
      end
   end

   // watchdog
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // offer one command word, hold it until taken; valid stays up for a follow-on word
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, id};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, id);
   endtask

   // miss limit only changes with the unit idle and nothing owed
   task automatic write_limit(input logic [MISS_W-1:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.miss_limit = value;
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(99) < 80) return id_pool[$urandom_range(POOL_SIZE-1)];
      return ID_W'($urandom());
   endfunction

   // mixed traffic over a small id pool so duplicates and refreshes hit
   task automatic run_random(input int count);
      int done;
      int pick;
      logic [CMD_W-1:0] cmd;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 38) cmd = CMD_REGISTER;
         else if (pick < 74) cmd = CMD_HEARTBEAT;
         else if (pick < 97) cmd = CMD_TICK;
         else cmd = CMD_UNUSED;
         send_word(cmd, pick_id());
         if (cmd != CMD_UNUSED) done++;
      end
   endtask

   initial begin
      logic [ID_W-1:0] fill_ids [ENTRIES + 2];
      sb = new;
      foreach (id_pool[i]) id_pool[i] = ID_W'($urandom());
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, ok, duplicate and not-found status, unused code, default limit
      send_idle_pct = 12;
      recv_idle_pct = 46;
      send_word(CMD_TICK, '0);
      send_word(CMD_REGISTER, 31'h0000_0000);
      send_word(CMD_REGISTER, 31'h7FFF_FFFF);
      send_word(CMD_REGISTER, 31'h2AAA_AAAA);
      send_word(CMD_REGISTER, 31'h0000_0000);
      send_word(CMD_HEARTBEAT, 31'h7FFF_FFFF);
      send_word(CMD_HEARTBEAT, 31'h5555_5555);
      send_word(CMD_UNUSED, 31'h5555_5555);
      send_word(CMD_TICK, 31'h7FFF_FFFF);
      send_word(CMD_HEARTBEAT, 31'h0000_0000);
      repeat (4) send_word(CMD_TICK, '0);

      // limit zero: gone on the first missed tick
      write_limit(4'd0);
      send_word(CMD_REGISTER, 31'h5555_5555);
      send_word(CMD_TICK, '0);
      send_word(CMD_TICK, '0);

      write_limit(4'd1);
      run_random(6);

      // fill past capacity behind a long result stall, then sweep everything out
      write_limit(4'd1);
      send_idle_pct = 46;
      recv_idle_pct = 12;
      hold_request  = 400;
      foreach (fill_ids[i]) begin
         fill_ids[i] = ID_W'($urandom());
         send_word(CMD_REGISTER, fill_ids[i]);
      end
      repeat (2) send_word(CMD_HEARTBEAT, fill_ids[$urandom_range(ENTRIES-1)]);
      send_word(CMD_TICK, '0);
      send_word(CMD_TICK, '0);

      // top limit: needs fifteen straight misses
      write_limit(4'd15);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(CMD_REGISTER, pick_id());
      repeat (16) send_word(CMD_TICK, '0);

      write_limit(4'($urandom_range(2, 6)));
      run_random(4);

      // drain
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
